FILE: sv/psrm_pkg.sv
// psrm_pkg: shared constants, types and state codes for the phase stereo row matcher
// no dependencies; used by every module in sv/
package psrm_pkg;

  localparam int ROW_WIDTH = 1024;
  localparam int COL_W     = $clog2(ROW_WIDTH);
  localparam int CNT_W     = $clog2(ROW_WIDTH + 1);
  localparam int PH_W      = 24;
  localparam int ROW_W     = 12;
  localparam int POS_W     = 20;
  localparam int MEM_W     = PH_W + 1;
  localparam int PROD_W    = PH_W + COL_W;
  localparam int DVD_W     = PROD_W + 10;
  localparam int DVS_W     = PH_W + 1;
  localparam int DIV_STEPS = DVD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);
  localparam int WIDE_W    = DVD_W + 2;
  localparam logic [PH_W-1:0] THRESH_RESET = 24'd410;
  localparam logic [2:0] ADDR_THRESH = 3'd0;

  localparam logic signed [WIDE_W-1:0] POS_MAX = WIDE_W'(524287);
  localparam logic signed [WIDE_W-1:0] POS_MIN = -WIDE_W'(524288);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_ORDER = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_DGO   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: sv/psrm_row_mem.sv
// psrm_row_mem: right row store, {mask, phase} per column, one write and one read port
// depends on psrm_pkg
module psrm_row_mem (
  input  logic                          clk,
  input  logic                          we,
  input  logic [psrm_pkg::COL_W-1:0]    waddr,
  input  logic [psrm_pkg::MEM_W-1:0]    wdata,
  input  logic                          re,
  input  logic [psrm_pkg::COL_W-1:0]    raddr,
  output logic [psrm_pkg::MEM_W-1:0]    rdata
);

  logic [psrm_pkg::MEM_W-1:0] mem [psrm_pkg::ROW_WIDTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/psrm_divider.sv
// psrm_divider: restoring unsigned divider, one quotient bit per cycle
// depends on psrm_pkg
module psrm_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [psrm_pkg::DVD_W-1:0]    dividend,
  input  logic [psrm_pkg::DVS_W-1:0]    divisor,
  output logic [psrm_pkg::DVD_W-1:0]    quotient,
  output psrm_pkg::div_stat_t           stat
);

  logic [psrm_pkg::DVS_W-1:0]  rem_r, rem_nxt;
  logic [psrm_pkg::DVD_W-1:0]  quo_r, quo_nxt;
  logic [psrm_pkg::DVS_W-1:0]  dvs_r;
  logic [psrm_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [psrm_pkg::DVS_W:0]    trial;
  logic                        fits;

  // one shift-subtract step
  always_comb begin
    trial    = {rem_r, quo_r[psrm_pkg::DVD_W-1]};
    fits     = trial >= {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? psrm_pkg::DVS_W'(trial - {1'b0, dvs_r})
                     : trial[psrm_pkg::DVS_W-1:0];
      quo_nxt = {quo_r[psrm_pkg::DVD_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == psrm_pkg::STEP_W'(psrm_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: sv/phase_stereo_row_match.sv
// phase_stereo_row_match: top level, right row store, column scan, subpixel interpolation
// depends on psrm_pkg, psrm_row_mem, psrm_divider
//
//  channel | direction | handshake            | payload
//  in_     | slave     | tvalid/tready        | tdata 48b, tuser 1b (mode)
//  out_    | master    | tvalid/tready        | tdata 48b, tuser 1b (degenerate)
//  cfg_    | apb slave | psel/penable/pready  | 32b data, 3b byte address
//
// a load writes the row store when accepted. a valid query scans all 1024 stored columns, one memory
// read per cycle, then orders the pair, multiplies and runs the 44-step divider, which a
// degenerate pair skips. invalid queries return to idle when accepted and give no result.
// rst_n is synchronous; the row store needs no clearing. in_tready is low while a
// query is in flight; a finished result waits in the output register.
module phase_stereo_row_match (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // column[9:0], row_index[21:10], phase[45:22], in_mask[46]
  input  logic        in_tuser,   // mode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // left_column[9:0], out_row[21:10], right_pos[41:22]
  output logic        out_tuser,  // degenerate[0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int PW = psrm_pkg::PH_W;
  localparam int CW = psrm_pkg::COL_W;

  // input fields
  logic [9:0]          f_col;
  logic [11:0]         f_row;
  logic [PW-1:0]       f_phase;
  logic                f_mask;
  logic                in_xfer;

  assign f_col   = in_tdata[9:0];
  assign f_row   = in_tdata[21:10];
  assign f_phase = in_tdata[45:22];
  assign f_mask  = in_tdata[46];
  assign in_xfer = in_tvalid && in_tready;

  psrm_pkg::state_t state_r, state_nxt;

  // threshold register
  logic [PW-1:0] thresh_r;
  logic          cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == psrm_pkg::ADDR_THRESH[2]) ? {8'd0, thresh_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= psrm_pkg::THRESH_RESET;
    end else if (cfg_wr && cfg_paddr[2] == psrm_pkg::ADDR_THRESH[2]) begin
      thresh_r <= cfg_pwdata[PW-1:0];
    end
  end

  // row store
  logic                        mem_we, mem_re;
  logic [psrm_pkg::MEM_W-1:0]  mem_rdata;
  logic [psrm_pkg::CNT_W-1:0]  addr_r;

  assign mem_we = in_xfer && in_tuser == psrm_pkg::MODE_LOAD
                  && {1'b0, f_col} < 11'(psrm_pkg::ROW_WIDTH);
  assign mem_re = state_r == psrm_pkg::S_SCAN
                  && addr_r < psrm_pkg::CNT_W'(psrm_pkg::ROW_WIDTH);

  psrm_row_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (f_col[CW-1:0]),
    .wdata ({f_mask, f_phase}),
    .re    (mem_re),
    .raddr (addr_r[CW-1:0]),
    .rdata (mem_rdata)
  );

  // query context
  logic [9:0]    qcol_r;
  logic [11:0]   qrow_r;
  logic [PW-1:0] pl_r;
  logic          rd_vld_r;
  logic [CW-1:0] rd_col_r;

  // best two candidates
  logic [PW-1:0] bd0_r, bd1_r, bp0_r, bp1_r;
  logic [CW-1:0] bc0_r, bc1_r;
  logic [1:0]    cnt_r;

  logic [PW-1:0] rph;
  logic          rmask;
  logic [PW-1:0] diff;
  logic          cand;
  assign rph   = mem_rdata[PW-1:0];
  assign rmask = mem_rdata[PW];
  assign diff  = (pl_r >= rph) ? pl_r - rph : rph - pl_r;
  assign cand  = rd_vld_r && rmask && diff <= thresh_r;

  // pair ordering and interpolation operands
  logic [CW-1:0]  x1, x2;
  logic [PW-1:0]  p1, p2;
  logic [CW-1:0]  x2_r, dx_r;
  logic [PW-1:0]  absn_r, den_r;
  logic           neg_r, degen_r;
  logic [psrm_pkg::PROD_W-1:0] prod_r;

  always_comb begin
    if (bc0_r < bc1_r) begin
      x1 = bc0_r; x2 = bc1_r; p1 = bp0_r; p2 = bp1_r;
    end else begin
      x1 = bc1_r; x2 = bc0_r; p1 = bp1_r; p2 = bp0_r;
    end
  end

  // divider
  logic                        div_start;
  logic [psrm_pkg::DVD_W-1:0]  div_quot;
  psrm_pkg::div_stat_t         div_stat;
  assign div_start = state_r == psrm_pkg::S_DGO;

  psrm_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (psrm_pkg::DVD_W'({prod_r, 9'd0}) + psrm_pkg::DVD_W'(den_r)),
    .divisor  ({den_r, 1'b0}),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // final position with saturation
  logic signed [psrm_pkg::WIDE_W-1:0] qs, pos;
  logic [psrm_pkg::POS_W-1:0]         pos_r;
  always_comb begin
    qs = degen_r ? '0 : $signed(psrm_pkg::WIDE_W'(div_quot));
    if (neg_r) begin
      qs = -qs;
    end
    pos = $signed(psrm_pkg::WIDE_W'({x2_r, 8'd0})) - qs;
  end

  // output register
  logic        out_vld_r;
  logic [47:0] out_data_r;
  logic        out_user_r;
  logic        out_load;
  assign out_load   = state_r == psrm_pkg::S_OUT && (!out_vld_r || out_tready);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign in_tready  = state_r == psrm_pkg::S_IDLE;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psrm_pkg::S_IDLE: begin
        if (in_xfer && in_tuser == psrm_pkg::MODE_QUERY && f_mask && f_phase != '0) begin
          state_nxt = psrm_pkg::S_SCAN;
        end
      end
      psrm_pkg::S_SCAN: begin
        if (addr_r == psrm_pkg::CNT_W'(psrm_pkg::ROW_WIDTH) && !rd_vld_r) begin
          state_nxt = psrm_pkg::S_ORDER;
        end
      end
      psrm_pkg::S_ORDER: state_nxt = (cnt_r < 2'd2) ? psrm_pkg::S_IDLE : psrm_pkg::S_MUL;
      psrm_pkg::S_MUL:   state_nxt = degen_r ? psrm_pkg::S_FIN : psrm_pkg::S_DGO;
      psrm_pkg::S_DGO:   state_nxt = psrm_pkg::S_DIV;
      psrm_pkg::S_DIV: begin
        if (div_stat.done) begin
          state_nxt = psrm_pkg::S_FIN;
        end
      end
      psrm_pkg::S_FIN:   state_nxt = psrm_pkg::S_OUT;
      psrm_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = psrm_pkg::S_IDLE;
        end
      end
      default:           state_nxt = psrm_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= psrm_pkg::S_IDLE;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      addr_r    <= '0;
      cnt_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= mem_re;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (state_r == psrm_pkg::S_IDLE) begin
        addr_r <= '0;
        cnt_r  <= '0;
      end else begin
        if (mem_re) begin
          addr_r <= addr_r + 1'b1;
        end
        if (cand && cnt_r < 2'd2) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      qcol_r <= f_col;
      qrow_r <= f_row;
      pl_r   <= f_phase;
    end
    rd_col_r <= addr_r[CW-1:0];
    // keep the two smallest distances, lower column wins ties
    if (cand && state_r == psrm_pkg::S_SCAN) begin
      if (cnt_r == 2'd0 || diff < bd0_r) begin
        bd1_r <= bd0_r; bc1_r <= bc0_r; bp1_r <= bp0_r;
        bd0_r <= diff;  bc0_r <= rd_col_r; bp0_r <= rph;
      end else if (cnt_r == 2'd1 || diff < bd1_r) begin
        bd1_r <= diff;  bc1_r <= rd_col_r; bp1_r <= rph;
      end
    end
    if (state_r == psrm_pkg::S_ORDER) begin
      x2_r    <= x2;
      dx_r    <= x2 - x1;
      absn_r  <= (p2 >= pl_r) ? p2 - pl_r : pl_r - p2;
      den_r   <= (p2 >= p1) ? p2 - p1 : p1 - p2;
      neg_r   <= (p2 < pl_r) != (p2 < p1);
      degen_r <= p1 == p2;
    end
    if (state_r == psrm_pkg::S_MUL) begin
      prod_r <= absn_r * dx_r;
    end
    if (state_r == psrm_pkg::S_FIN) begin
      if (pos > psrm_pkg::POS_MAX) begin
        pos_r <= psrm_pkg::POS_MAX[psrm_pkg::POS_W-1:0];
      end else if (pos < psrm_pkg::POS_MIN) begin
        pos_r <= psrm_pkg::POS_MIN[psrm_pkg::POS_W-1:0];
      end else begin
        pos_r <= pos[psrm_pkg::POS_W-1:0];
      end
    end
    if (out_load) begin
      out_data_r <= {6'd0, pos_r, qrow_r, qcol_r};
      out_user_r <= degen_r;
    end
  end

  // checks
  a_no_write_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != psrm_pkg::S_IDLE |-> !mem_we)
    else $error("row store written during a query");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == psrm_pkg::S_OUT))
    else $error("result transfer raised outside the output step");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == psrm_pkg::S_DIV)
    else $error("divider running outside the divide step");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("candidate count overflow");

endmodule

FILE: tb/sv/tb_phase_stereo_row_match.sv
// tb_phase_stereo_row_match: self-checking testbench for the phase stereo row matcher
// depends on psrm_pkg and phase_stereo_row_match; scoreboard class predicts every match
`timescale 1ns / 100ps

module tb_phase_stereo_row_match;

  // register address with no register behind it
  localparam logic [2:0] ADDR_NONE = 3'd4;

  // expected match record
  typedef struct {
    logic [9:0]  left_col;
    logic [11:0] row;
    logic [19:0] pos;
    logic        degen;
  } match_t;

  // right row mirror, threshold copy and queue of pending matches
  class match_board;
    logic [23:0] row_phase[1024];
    logic        row_mask[1024];
    logic [23:0] thresh;
    match_t      pending[$];
    int          errors;

    function new();
      thresh = psrm_pkg::THRESH_RESET;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // rounded quotient, ties away from zero
    function longint round_div(longint num, longint den);
      longint unsigned a, b, q;
      bit neg;
      neg = (num < 0) != (den < 0);
      a = (num < 0) ? -num : num;
      b = (den < 0) ? -den : den;
      q = (2 * a + b) / (2 * b);
      return neg ? -longint'(q) : longint'(q);
    endfunction

    // note an accepted input transfer
    function void note_input(psrm_pkg::mode_t mode, logic [9:0] col, logic [11:0] row,
                             logic [23:0] ph, logic msk);
      longint bd0, bd1, d, pl, p1, p2, pos;
      int bc0, bc1, cnt, x1, x2;
      match_t m;
      bd0 = 0; bd1 = 0; bc0 = 0; bc1 = 0; cnt = 0;
      if (mode == psrm_pkg::MODE_LOAD) begin
        row_phase[col] = ph;
        row_mask[col] = msk;
        return;
      end
      if (!msk || ph == 0) return;
      pl = ph;
      // keep the two nearest masked columns within the threshold
      for (int k = 0; k < 1024; k++) begin
        if (!row_mask[k]) continue;
        d = pl - longint'(row_phase[k]);
        if (d < 0) d = -d;
        if (d > longint'(thresh)) continue;
        if (cnt == 0 || d < bd0) begin
          bd1 = bd0; bc1 = bc0; bd0 = d; bc0 = k;
        end else if (cnt == 1 || d < bd1) begin
          bd1 = d; bc1 = k;
        end
        if (cnt < 2) cnt++;
      end
      if (cnt < 2) return;
      x1 = (bc0 < bc1) ? bc0 : bc1;
      x2 = (bc0 < bc1) ? bc1 : bc0;
      p1 = row_phase[x1];
      p2 = row_phase[x2];
      pos = longint'(x2) * 256;
      m.degen = (p1 == p2);
      if (p1 != p2) pos -= round_div((p2 - pl) * longint'(x2 - x1) * 256, p2 - p1);
      if (pos > 524287) pos = 524287;
      if (pos < -524288) pos = -524288;
      m.left_col = col;
      m.row = row;
      m.pos = pos[19:0];
      pending = {pending, m};
    endfunction

    // compare one result transfer with the oldest expectation
    task check_result(logic [9:0] col, logic [11:0] row, logic [19:0] pos, logic degen);
      match_t m;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result col %0d row %0d", col, row));
        return;
      end
      m = pending.pop_front();
      if (col !== m.left_col)
        report($sformatf("left_column %0d, want %0d", col, m.left_col));
      if (row !== m.row)
        report($sformatf("out_row %0d, want %0d", row, m.row));
      if (pos !== m.pos)
        report($sformatf("right_pos %0h, want %0h (col %0d)", pos, m.pos, m.left_col));
      if (degen !== m.degen)
        report($sformatf("degenerate %0b, want %0b (col %0d)", degen, m.degen, m.left_col));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // column[9:0], row_index[21:10], phase[45:22], in_mask[46]
  logic        in_tuser = 0;    // mode[0]
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [47:0] out_tdata;       // left_column[9:0], out_row[21:10], right_pos[41:22]
  logic        out_tuser;       // degenerate[0]
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  match_board  board = new();
  int          in_gap_max = 14;
  int          out_gap_max = 14;
  logic [23:0] ramp_base;
  int          ramp_step;

  phase_stereo_row_match dut (.*);

  always #5 clk = ~clk;

  // result side: random stall before each transfer
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      gap = $urandom_range(out_gap_max, 0);
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata[9:0], out_tdata[21:10], out_tdata[41:22], out_tuser);
  end

  // drive one input transfer
  task send(psrm_pkg::mode_t mode, logic [9:0] col, logic [11:0] row, logic [23:0] ph,
            logic msk);
    int gap;
    gap = $urandom_range(in_gap_max, 0);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= mode;
    in_tdata <= {1'b0, msk, ph, row, col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(mode, col, row, ph, msk);
  endtask

  // apb write, only while the block is idle
  task cfg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    if (addr == psrm_pkg::ADDR_THRESH) board.thresh = data[23:0];
    @(posedge clk);
  endtask

  // drain: all expected results in, then room for a query that makes none
  task drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  // fill the whole right row with a ramp, masked and replaced by noise at the given rates
  task load_ramp(int mask_pct, int noise_pct);
    logic [23:0] ph;
    in_gap_max = $urandom_range(1, 0);
    for (int k = 0; k < 1024; k++) begin
      ph = ramp_base + 24'(k * ramp_step);
      if ($urandom_range(99, 0) < noise_pct) ph = 24'($urandom);
      send(psrm_pkg::MODE_LOAD, k[9:0], 12'($urandom), ph, $urandom_range(99, 0) < mask_pct);
    end
  endtask

  // query near the stored phase of a random column, now and then at a random phase
  task query_near();
    int k, off;
    longint pl;
    k = $urandom_range(1023, 0);
    off = $urandom_range(2 * ramp_step + 2, 0) - ramp_step - 1;
    pl = longint'(board.row_phase[k]) + off;
    if (pl < 1) pl = 1;
    if (pl > 24'hFFFFFF) pl = 24'hFFFFFF;
    if ($urandom_range(9, 0) == 0) pl = $urandom_range(24'hFFFFFF, 0);
    send(psrm_pkg::MODE_QUERY, 10'($urandom), 12'($urandom), pl[23:0],
         $urandom_range(9, 0) != 0);
  endtask

  initial begin
    logic [31:0] th;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: default threshold, unknown register, plain ramp
    cfg_write(psrm_pkg::ADDR_THRESH, 32'(psrm_pkg::THRESH_RESET));
    cfg_write(ADDR_NONE, 32'hFFFF_FFFF);
    ramp_base = 24'd1000;
    ramp_step = 100;
    load_ramp(100, 0);
    in_gap_max = 14;
    send(psrm_pkg::MODE_LOAD, 10'd500, 12'd0, 24'd7777777, 1);
    send(psrm_pkg::MODE_LOAD, 10'd501, 12'd0, 24'd7777777, 1);
    send(psrm_pkg::MODE_LOAD, 10'd600, 12'd0, 24'd5999950, 1);
    send(psrm_pkg::MODE_LOAD, 10'd601, 12'd0, 24'd6000050, 1);
    send(psrm_pkg::MODE_LOAD, 10'd602, 12'd0, 24'd6000050, 1);
    send(psrm_pkg::MODE_LOAD, 10'd700, 12'd0, 24'd3000000, 0);
    send(psrm_pkg::MODE_QUERY, 10'd0, 12'd0, 24'd5000, 1);
    send(psrm_pkg::MODE_QUERY, 10'd1023, 12'd4095, 24'd5050, 1);
    send(psrm_pkg::MODE_QUERY, 10'd5, 12'd7, 24'd5000, 0);
    send(psrm_pkg::MODE_QUERY, 10'd6, 12'd7, 24'd0, 1);
    send(psrm_pkg::MODE_QUERY, 10'd7, 12'd7, 24'd7777777, 1);   // equal candidate phases
    send(psrm_pkg::MODE_QUERY, 10'd8, 12'd7, 24'd6000000, 1);   // equal differences
    send(psrm_pkg::MODE_QUERY, 10'd9, 12'd7, 24'd3000000, 1);   // masked-out only
    send(psrm_pkg::MODE_QUERY, 10'd10, 12'd7, 24'hFFFFFF, 1);
    send(psrm_pkg::MODE_QUERY, 10'd11, 12'd7, 24'd1000, 1);
    drain();

    // saturation both ways with the widest threshold
    cfg_write(psrm_pkg::ADDR_THRESH, 32'h00FF_FFFF);
    send(psrm_pkg::MODE_LOAD, 10'd0, 12'd0, 24'd16776999, 1);
    send(psrm_pkg::MODE_LOAD, 10'd1023, 12'd0, 24'd16777000, 1);
    send(psrm_pkg::MODE_QUERY, 10'd12, 12'd9, 24'hFFFFFF, 1);
    send(psrm_pkg::MODE_LOAD, 10'd0, 12'd0, 24'd16777000, 1);
    send(psrm_pkg::MODE_LOAD, 10'd1023, 12'd0, 24'd16776999, 1);
    send(psrm_pkg::MODE_QUERY, 10'd13, 12'd9, 24'hFFFFFF, 1);
    drain();
    cfg_write(psrm_pkg::ADDR_THRESH, 32'd0);
    send(psrm_pkg::MODE_QUERY, 10'd14, 12'd9, 24'd16777000, 1);
    drain();

    // random phases: new threshold, then queries with sporadic loads on the stored row
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: th = 0;
        1: th = 32'h00FF_FFFF;
        default: th = $urandom_range(2000, 1);
      endcase
      cfg_write(psrm_pkg::ADDR_THRESH, th);
      in_gap_max = (p % 3 == 2) ? 0 : 14;
      out_gap_max = (p % 3 == 1) ? 0 : 14;
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(9, 0) < 2)
          send(psrm_pkg::MODE_LOAD, 10'($urandom), 12'($urandom),
               ramp_base + 24'($urandom_range(1023, 0) * ramp_step),
               1'($urandom_range(1, 0)));
        else
          query_near();
      end
      drain();
      out_gap_max = 14;
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #60ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
sv/psrm_pkg.sv
sv/psrm_row_mem.sv
sv/psrm_divider.sv
sv/phase_stereo_row_match.sv
tb/sv/tb_phase_stereo_row_match.sv
